>>> rtl/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types and constants for the heater PID / time-proportioning core.
// ----------------------------------------------------------------------------
package hpid_pkg;

    // field widths
    localparam int TEMP_W     = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int INT_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int TICK_W     = 32;
    localparam int DRIVE_W    = 11;
    localparam int ONMS_W     = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // product and sum widths (gain is zero-extended to signed)
    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + INT_W;
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W = 37;
    localparam int DRIVE_SHIFT = 9;

    // control constants
    localparam logic signed [ERR_W-1:0]   FF_LIMIT   = 17'sd320;
    localparam logic signed [ERR_W-1:0]   BAND_POS   = 17'sd160;
    localparam logic signed [ERR_W-1:0]   BAND_NEG   = -17'sd160;
    localparam logic signed [INT_W:0]     INT_POS    = 14'sd3200;
    localparam logic signed [INT_W:0]     INT_NEG    = -14'sd3200;
    localparam logic signed [SUM_W-1:0]   FULL_NUM   = 37'sd819200;
    localparam logic [DRIVE_W-1:0]        FULL_DRIVE = 11'd1600;
    localparam logic [DRIVE_W-1:0]        NEAR_FULL  = 11'd1584;
    localparam logic [DRIVE_W-1:0]        NEAR_ZERO  = 11'd16;
    localparam logic [TICK_W-1:0]         CYCLE_MS   = 32'd2000;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D   = 3'd4;

    // reset values
    localparam logic [TEMP_W-1:0] RST_SETPOINT = 16'd2880;
    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 16'd1024;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 16'd20;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 16'd77;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              ok;
        logic              aux_ok;
        logic [TICK_W-1:0] tick;
    } t_item;

    typedef struct packed {
        logic              active;
        logic              ff;
        logic [ERR_W-1:0]  e;
        logic [INT_W-1:0]  integ;
        logic [DIFF_W-1:0] diff;
        logic              ok;
        logic              aux_ok;
        logic [TEMP_W-1:0] held_temp;
        logic [TICK_W-1:0] tick;
    } t_err;

    typedef struct packed {
        logic               active;
        logic [DRIVE_W-1:0] drive;
        logic               ok;
        logic               aux_ok;
        logic [TEMP_W-1:0]  held_temp;
        logic [TICK_W-1:0]  tick;
    } t_drv;

    typedef struct packed {
        logic               heater_on;
        logic               sensor_fault;
        logic [DRIVE_W-1:0] drive_level;
        logic [TEMP_W-1:0]  latest_temp;
    } t_res;

endpackage

>>> rtl/hpid_err.sv
// ----------------------------------------------------------------------------
// hpid_err
// Error stage: held temperature, error, windup-limited integral, derivative.
// ----------------------------------------------------------------------------
module hpid_err (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_load,
    input  hpid_pkg::t_item                 i_item,
    input  logic [hpid_pkg::TEMP_W-1:0]     i_setpoint,
    input  logic                            i_enable,
    output hpid_pkg::t_err                  o_err
);
    import hpid_pkg::*;

    logic [TEMP_W-1:0]        r_held_temp;
    logic signed [INT_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]  r_prev;
    t_err                     r_out;

    logic [TEMP_W-1:0]        w_temp;
    logic signed [ERR_W-1:0]  w_e;
    logic                     w_active;
    logic                     w_ff;
    logic                     w_in_band;
    logic signed [INT_W:0]    w_sum;
    logic signed [INT_W:0]    w_clamp;
    logic signed [INT_W-1:0]  w_integ;
    logic signed [DIFF_W-1:0] w_diff;

    assign w_temp    = i_item.ok ? i_item.temp : r_held_temp;
    assign w_e       = $signed({i_setpoint[TEMP_W-1], i_setpoint})
                     - $signed({w_temp[TEMP_W-1], w_temp});
    assign w_active  = i_enable & i_item.ok;
    assign w_ff      = (w_e > FF_LIMIT);
    assign w_in_band = (w_e < BAND_POS) && (w_e > BAND_NEG);
    // inside the band |e| < 160, so the low bits carry it exactly
    assign w_sum     = $signed({r_integ[INT_W-1], r_integ})
                     + (w_in_band ? $signed(w_e[INT_W:0]) : '0);

    always_comb begin
        if (w_sum > INT_POS) begin
            w_clamp = INT_POS;
        end else if (w_sum < INT_NEG) begin
            w_clamp = INT_NEG;
        end else begin
            w_clamp = w_sum;
        end
    end

    assign w_integ = w_ff ? '0 : w_clamp[INT_W-1:0];
    assign w_diff  = $signed({w_e[ERR_W-1], w_e}) - $signed({r_prev[ERR_W-1], r_prev});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_temp <= '0;
            r_integ     <= '0;
            r_prev      <= '0;
        end else if (i_load) begin
            if (i_item.ok) begin
                r_held_temp <= i_item.temp;
            end
            if (w_active) begin
                r_integ <= w_integ;
                r_prev  <= w_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.active    <= w_active;
            r_out.ff        <= w_ff;
            r_out.e         <= w_e;
            r_out.integ     <= w_integ;
            r_out.diff      <= w_diff;
            r_out.ok        <= i_item.ok;
            r_out.aux_ok    <= i_item.aux_ok;
            r_out.held_temp <= w_temp;
            r_out.tick      <= i_item.tick;
        end
    end

    assign o_err = r_out;

endmodule

>>> rtl/hpid_drive.sv
// ----------------------------------------------------------------------------
// hpid_drive
// Two stages: gain products, then numerator sum, scale and clamp to 0..1600.
// ----------------------------------------------------------------------------
module hpid_drive (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  hpid_pkg::t_err                  i_err,
    input  logic [hpid_pkg::GAIN_W-1:0]     i_gain_p,
    input  logic [hpid_pkg::GAIN_W-1:0]     i_gain_i,
    input  logic [hpid_pkg::GAIN_W-1:0]     i_gain_d,
    output hpid_pkg::t_drv                  o_drv
);
    import hpid_pkg::*;

    logic signed [PP_W-1:0]  w_pp;
    logic signed [PI_W-1:0]  w_pi;
    logic signed [PD_W-1:0]  w_pd;
    logic signed [PP_W-1:0]  r_pp;
    logic signed [PI_W-1:0]  r_pi;
    logic signed [PD_W-1:0]  r_pd;
    t_err                    r_c;
    logic signed [SUM_W-1:0] w_n;
    logic [DRIVE_W-1:0]      w_drive;
    t_drv                    r_d;

    assign w_pp = $signed({1'b0, i_gain_p}) * $signed(i_err.e);
    assign w_pi = $signed({1'b0, i_gain_i}) * $signed(i_err.integ);
    assign w_pd = $signed({1'b0, i_gain_d}) * $signed(i_err.diff);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= w_pp;
            r_pi <= w_pi;
            r_pd <= w_pd;
            r_c  <= i_err;
        end
    end

    // n = 2*Kp*e + Ki*I + 2*Kd*de
    assign w_n = $signed({{(SUM_W-PP_W-1){r_pp[PP_W-1]}}, r_pp, 1'b0})
               + $signed({{(SUM_W-PI_W){r_pi[PI_W-1]}}, r_pi})
               + $signed({{(SUM_W-PD_W-1){r_pd[PD_W-1]}}, r_pd, 1'b0});

    always_comb begin
        if (r_c.ff) begin
            w_drive = FULL_DRIVE;
        end else if (w_n <= 0) begin
            w_drive = '0;
        end else if (w_n >= FULL_NUM) begin
            w_drive = FULL_DRIVE;
        end else begin
            w_drive = w_n[DRIVE_SHIFT+DRIVE_W-1:DRIVE_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.active    <= r_c.active;
            r_d.drive     <= w_drive;
            r_d.ok        <= r_c.ok;
            r_d.aux_ok    <= r_c.aux_ok;
            r_d.held_temp <= r_c.held_temp;
            r_d.tick      <= r_c.tick;
        end
    end

    assign o_drv = r_d;

endmodule

>>> rtl/hpid_cycle.sv
// ----------------------------------------------------------------------------
// hpid_cycle
// Time-proportioning window (2000 ms) and result register.
// ----------------------------------------------------------------------------
module hpid_cycle (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_load,
    input  hpid_pkg::t_drv i_drv,
    output hpid_pkg::t_res o_res
);
    import hpid_pkg::*;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [TICK_W-1:0]    r_start;
    logic [TICK_W-1:0]    n_start;
    logic [DRIVE_W-1:0]   r_drive;
    logic [DRIVE_W-1:0]   n_drive;
    logic                 w_heat;
    logic [DRIVE_W+1:0]   w_on5;
    logic [ONMS_W-1:0]    w_on_ms;
    logic [TICK_W-1:0]    w_elapsed;
    t_res                 r_res;

    // on time = drive * 5 / 4 ms
    assign w_on5     = {2'b00, i_drv.drive} + {i_drv.drive, 2'b00};
    assign w_on_ms   = w_on5[DRIVE_W+1:2];
    assign w_elapsed = i_drv.tick - r_start;

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_drive = r_drive;
        w_heat  = 1'b0;
        if (!i_drv.active) begin
            n_phase = PH_IDLE;
        end else begin
            n_drive = i_drv.drive;
            if (i_drv.drive >= NEAR_FULL) begin
                w_heat  = 1'b1;
                n_phase = PH_IDLE;
            end else if (i_drv.drive <= NEAR_ZERO) begin
                n_phase = PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_ON;
                        n_start = i_drv.tick;
                        w_heat  = 1'b1;
                    end
                    PH_ON: begin
                        if (w_elapsed >= {{(TICK_W-ONMS_W){1'b0}}, w_on_ms}) begin
                            n_phase = PH_OFF;
                        end else begin
                            w_heat = 1'b1;
                        end
                        if (w_elapsed >= CYCLE_MS) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        if (w_elapsed >= CYCLE_MS) begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_start <= '0;
            r_drive <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.heater_on    <= w_heat;
            r_res.sensor_fault <= ~(i_drv.ok & i_drv.aux_ok);
            r_res.drive_level  <= n_drive;
            r_res.latest_temp  <= i_drv.held_temp;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/heater_pid_time_proportioning_core.sv
// ----------------------------------------------------------------------------
// heater_pid_time_proportioning_core
// PID temperature loop with a 2000 ms time-proportioned heater output.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | carries
//  ----------+-----------+----------------------------+---------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..tready | one control tick item
//  m_axis    | out       | o_m_axis_tvalid/i_..tready | one result item per tick
//  cfg       | in        | i_cfg_valid/o_cfg_ready    | register index + data
//
//  One item per cycle while results are taken; each passes through five
//  registers: input, error/integral, product, sum/clamp, cycle/result.
//  The loop state (integral, previous error, window phase) lives inside the
//  stage that uses it, so consecutive items never wait on each other.
//  Synchronous active-low reset clears pipeline and loop state and presets the config registers.
//  A stalled result freezes the whole pipeline; s_axis ready drops only then.
//  Config is always ready and must only be written while the core is empty.
//
module heater_pid_time_proportioning_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick in
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [47:0]                         i_s_axis_tdata,  // [15:0] sensor_temp, [47:16] tick_ms
    input  logic [1:0]                          i_s_axis_tuser,  // [0] sensor_ok, [1] aux_sensor_ok
    // result out
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [31:0]                         o_m_axis_tdata,  // [10:0] drive_level,
                                                                 // [26:11] latest_temp, [31:27] zero
    output logic [1:0]                          o_m_axis_tuser,  // [0] heater_on, [1] sensor_fault
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hpid_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [hpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hpid_pkg::*;

    // configuration registers
    logic [TEMP_W-1:0] r_setpoint;
    logic              r_enable;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;

    // pipeline
    t_item r_a;
    logic  r_v_a;
    logic  r_v_b;
    logic  r_v_c;
    logic  r_v_d;
    logic  r_v_e;
    logic  w_adv;
    t_err  w_err;
    t_drv  w_drv;
    t_res  w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= RST_SETPOINT;
            r_enable   <= 1'b0;
            r_gain_p   <= RST_GAIN_P;
            r_gain_i   <= RST_GAIN_I;
            r_gain_d   <= RST_GAIN_D;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_SETPOINT: r_setpoint <= i_cfg_data;
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_GAIN_P:   r_gain_p   <= i_cfg_data;
                CFG_GAIN_I:   r_gain_i   <= i_cfg_data;
                CFG_GAIN_D:   r_gain_d   <= i_cfg_data;
                default: ;    // unmapped index, ignored
            endcase
        end
    end

    // whole pipeline moves unless a finished result is held up
    assign w_adv           = ~r_v_e | i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
            r_v_e <= 1'b0;
        end else if (w_adv) begin
            r_v_a <= i_s_axis_tvalid;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b;
            r_v_d <= r_v_c;
            r_v_e <= r_v_d;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a.temp   <= i_s_axis_tdata[15:0];
            r_a.tick   <= i_s_axis_tdata[47:16];
            r_a.ok     <= i_s_axis_tuser[0];
            r_a.aux_ok <= i_s_axis_tuser[1];
        end
    end

    hpid_err u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_load     (w_adv & r_v_a),
        .i_item     (r_a),
        .i_setpoint (r_setpoint),
        .i_enable   (r_enable),
        .o_err      (w_err)
    );

    hpid_drive u_drive (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_err    (w_err),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .o_drv    (w_drv)
    );

    hpid_cycle u_cycle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_load  (w_adv & r_v_d),
        .i_drv   (w_drv),
        .o_res   (w_res)
    );

    assign o_m_axis_tvalid = r_v_e;
    assign o_m_axis_tdata  = {5'b00000, w_res.latest_temp, w_res.drive_level};
    assign o_m_axis_tuser  = {w_res.sensor_fault, w_res.heater_on};

    // drive never leaves 0..100 %
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[10:0] <= FULL_DRIVE))
        else $error("drive_level above full scale");

    // heater only runs with control enabled
    a_heat_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (r_enable && !(o_m_axis_tuser[1] &&
            !r_enable)))
        else $error("heater on while control disabled");

    // a result only appears after the sum/clamp stage held an item
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_v_d))
        else $error("result appeared without an item behind it");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heater PID / time-proportioning core. Control
// tick items go in on the stream slave, results are taken from the stream
// master, and each result is compared with a bit-true model of the loop
// that runs alongside the core.
// ----------------------------------------------------------------------------
module tb;

    import hpid_pkg::*;

    // loop constants, kept local so the model stands on its own
    localparam int FF_ERR    = 320;   // error above this gives full drive
    localparam int WINDUP    = 160;   // integral only accumulates inside +-WINDUP
    localparam int INT_CLAMP = 3200;
    localparam int DRIVE_MAX = 1600;
    localparam int DRIVE_HI  = 1584;  // at or above: heater fully on
    localparam int DRIVE_LO  = 16;    // at or below: heater fully off
    localparam int WINDOW_MS = 2000;

    // ------------------------------------------------------------------
    // clock and DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        tick_valid = 1'b0;
    logic [47:0] tick_data  = '0;   // [15:0] sensor_temp, [47:16] tick_ms
    logic [1:0]  tick_user  = '0;   // [0] sensor_ok, [1] aux_sensor_ok
    logic        res_ready  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;     // [10:0] drive_level, [26:11] latest_temp
    logic [1:0]  o_m_axis_tuser;     // [0] heater_on, [1] sensor_fault
    logic        o_cfg_ready;

    // idling odds, in percent per cycle
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int fail_count    = 0;
    int results_taken = 0;

    // expected results, oldest first
    t_res due_results[$];

    // ------------------------------------------------------------------
    // model of the controller: registers and loop state
    // ------------------------------------------------------------------
    logic signed [15:0] sp_reg     = 16'sd2880;
    logic               en_reg     = 1'b0;
    logic        [15:0] kp_reg     = 16'd1024;
    logic        [15:0] ki_reg     = 16'd20;
    logic        [15:0] kd_reg     = 16'd77;
    logic signed [12:0] integ_acc  = '0;
    logic signed [16:0] last_err   = '0;
    t_phase             win_phase  = PH_IDLE;
    logic        [31:0] win_start  = '0;
    logic signed [15:0] last_temp  = '0;
    logic        [10:0] last_drive = '0;

    heater_pid_time_proportioning_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (tick_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (tick_data),
        .i_s_axis_tuser  (tick_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // PID drive for one error; also moves the integral
    function automatic logic [10:0] pid_drive(input int err);
        int     acc;
        longint num;
        if (err > FF_ERR) begin
            // feedforward: flat out, integral dumped
            integ_acc = '0;
            return 11'(DRIVE_MAX);
        end
        acc = int'(integ_acc);
        if (err < WINDUP && err > -WINDUP)
            acc += err;
        if (acc > INT_CLAMP)  acc = INT_CLAMP;
        if (acc < -INT_CLAMP) acc = -INT_CLAMP;
        integ_acc = acc[12:0];
        num = 2 * longint'(kp_reg) * err
            + longint'(ki_reg) * acc
            + 2 * longint'(kd_reg) * (err - int'(last_err));
        if (num <= 0)
            return '0;
        if (num >= longint'(DRIVE_MAX) * 512)
            return 11'(DRIVE_MAX);
        return 11'(num / 512);
    endfunction

    // one control tick through the model: returns the expected result
    function automatic t_res predict_control_tick(input t_item it);
        t_res        r;
        int          err;
        logic        heat;
        logic [31:0] on_ms;
        logic [31:0] elapsed;
        heat = 1'b0;
        if (it.ok)
            last_temp = it.temp;
        if (!en_reg || !it.ok) begin
            // off: window restarts, everything else held
            win_phase = PH_IDLE;
        end else begin
            err        = int'(sp_reg) - int'(last_temp);
            last_drive = pid_drive(err);
            last_err   = err[16:0];
            on_ms      = (32'(last_drive) * 32'd5) >> 2;
            if (int'(last_drive) >= DRIVE_HI) begin
                heat      = 1'b1;
                win_phase = PH_IDLE;
            end else if (int'(last_drive) <= DRIVE_LO) begin
                win_phase = PH_IDLE;
            end else if (win_phase == PH_IDLE) begin
                win_phase = PH_ON;
                win_start = it.tick;
                heat      = 1'b1;
            end else begin
                // elapsed wraps with the timestamp
                elapsed = it.tick - win_start;
                if (win_phase == PH_ON) begin
                    if (elapsed >= on_ms)
                        win_phase = PH_OFF;
                    else
                        heat = 1'b1;
                end
                if (elapsed >= 32'(WINDOW_MS))
                    win_phase = PH_IDLE;
            end
        end
        r.heater_on    = heat;
        r.sensor_fault = !(it.ok && it.aux_ok);
        r.drive_level  = last_drive;
        r.latest_temp  = last_temp;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("mismatch on result %0d: %s got %0d want %0d",
                 results_taken, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_m_axis_tvalid && res_ready) begin
            results_taken++;
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing due", 1, 0);
            end else begin
                want = due_results.pop_front();
                if (o_m_axis_tuser[0] !== want.heater_on)
                    report_mismatch("heater_on", o_m_axis_tuser[0], want.heater_on);
                if (o_m_axis_tuser[1] !== want.sensor_fault)
                    report_mismatch("sensor_fault", o_m_axis_tuser[1], want.sensor_fault);
                if (o_m_axis_tdata[10:0] !== want.drive_level)
                    report_mismatch("drive_level", o_m_axis_tdata[10:0], want.drive_level);
                if (o_m_axis_tdata[26:11] !== want.latest_temp)
                    report_mismatch("latest_temp", $signed(o_m_axis_tdata[26:11]),
                                    $signed(want.latest_temp));
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one tick item; valid stays high afterwards unless the next call idles
    task automatic send_tick(input logic [15:0] t_in, input logic ok, input logic aux,
                             input logic [31:0] ms);
        t_item it;
        it.temp   = t_in;
        it.ok     = ok;
        it.aux_ok = aux;
        it.tick   = ms;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            tick_valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= {it.tick, it.temp};
        tick_user  <= {it.aux_ok, it.ok};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        due_results.push_back(predict_control_tick(it));
    endtask

    // drain: no item in flight, then let the pipeline settle
    task automatic wait_idle();
        tick_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register write; valid is left high so writes can go back to back
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SETPOINT: sp_reg = val;
            CFG_ENABLE:   en_reg = val[0];
            CFG_GAIN_P:   kp_reg = val;
            CFG_GAIN_I:   ki_reg = val;
            CFG_GAIN_D:   kd_reg = val;
            default: ;
        endcase
    endtask

    // full register set, only once the core has gone quiet
    task automatic set_controller(input logic [15:0] sp, input logic en, input logic [15:0] kp,
                                  input logic [15:0] ki, input logic [15:0] kd);
        wait_idle();
        cfg_write(CFG_SETPOINT, sp);
        // enable only looks at bit 0; junk above it
        cfg_write(CFG_ENABLE, {15'($urandom), en});
        cfg_write(CFG_GAIN_P, kp);
        cfg_write(CFG_GAIN_I, ki);
        cfg_write(CFG_GAIN_D, kd);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // straight out of reset: loop disabled, only the held temperature moves
    task automatic test_disabled_after_reset();
        send_tick(16'h8000, 1'b1, 1'b1, 32'h0000_0000);
        send_tick(16'h7FFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_tick(16'h1234, 1'b0, 1'b1, 32'h5555_5555);
        send_tick(16'h0ABC, 1'b0, 1'b0, 32'hAAAA_AAAA);
    endtask

    // enable only; setpoint and gains keep their reset values
    task automatic test_reset_gains();
        wait_idle();
        cfg_write(CFG_ENABLE, 16'h0001);
        cfg_valid <= 1'b0;
        send_tick(16'd2780, 1'b1, 1'b1, 32'd100);
        send_tick(16'd2860, 1'b1, 1'b1, 32'd200);
        send_tick(16'd2930, 1'b1, 1'b1, 32'd300);
    endtask

    // feedforward edge and the widest possible errors
    task automatic test_feedforward();
        set_controller(16'd1000, 1'b1, 16'd1024, 16'd20, 16'd77);
        send_tick(16'd679, 1'b1, 1'b1, 32'd1000);   // error 321
        send_tick(16'd680, 1'b1, 1'b1, 32'd1100);   // error 320, PID path
        set_controller(16'h7FFF, 1'b1, 16'd1024, 16'd20, 16'd77);
        send_tick(16'h8000, 1'b1, 1'b1, 32'd1200);  // error +65535
        set_controller(16'h8000, 1'b1, 16'd1024, 16'd20, 16'd77);
        send_tick(16'h7FFF, 1'b1, 1'b1, 32'd1300);  // error -65535
    endtask

    // anti-windup band edges
    task automatic test_windup_band();
        set_controller(16'd0, 1'b1, 16'd256, 16'd256, 16'd0);
        send_tick(-16'sd160, 1'b1, 1'b1, 32'd10);
        send_tick(-16'sd159, 1'b1, 1'b1, 32'd20);
        send_tick(16'sd160,  1'b1, 1'b1, 32'd30);
        send_tick(16'sd159,  1'b1, 1'b1, 32'd40);
    endtask

    // window: drive 200 gives 250 ms on, then off, then restart; lost sensor
    // drops to idle; a window that straddles the timestamp wrap
    task automatic test_window_cycle();
        set_controller(16'd1000, 1'b1, 16'd256, 16'd0, 16'd0);
        send_tick(16'd800, 1'b1, 1'b1, 32'd1000);   // starts, on
        send_tick(16'd800, 1'b1, 1'b1, 32'd1100);   // still on
        send_tick(16'd800, 1'b1, 1'b1, 32'd1300);   // on time spent
        send_tick(16'd800, 1'b1, 1'b1, 32'd3000);   // window over, off
        send_tick(16'd800, 1'b1, 1'b1, 32'd3100);   // next window
        send_tick(16'd800, 1'b0, 1'b1, 32'd3200);   // sensor lost
        send_tick(16'd800, 1'b1, 1'b1, 32'hFFFF_FF80);
        send_tick(16'd800, 1'b1, 1'b1, 32'h0000_0050);
        send_tick(16'd800, 1'b1, 1'b1, 32'h0000_00A0);
    endtask

    // all gains at full scale, then all at zero
    task automatic test_gain_extremes();
        set_controller(16'd2000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(16'd1999, 1'b1, 1'b1, 32'd500);
        send_tick(16'd2001, 1'b1, 1'b1, 32'd600);
        set_controller(16'd2000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'd1990, 1'b1, 1'b1, 32'd700);
    endtask

    // gain pick: mostly moderate, sometimes anything
    function automatic logic [15:0] pick_gain(input int top);
        if ($urandom_range(0, 99) < 15)
            return 16'($urandom);
        return 16'($urandom_range(0, top));
    endfunction

    // blocks of ticks under a fresh setting each; mostly a plausible
    // temperature trace around the setpoint with time moving on, some noise
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int          blk;
        int          i;
        int          drift;
        int          t_val;
        logic [31:0] now_ms;
        logic [15:0] sp;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (blk = 0; blk < n_items / 130; blk++) begin
            if (blk == 0) begin
                // corners of every register
                set_controller($urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 1'b1,
                               $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                               $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                               $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            end else begin
                sp = ($urandom_range(0, 99) < 15) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 4000));
                set_controller(sp, ($urandom_range(0, 99) >= 15), pick_gain(3000),
                               pick_gain(300), pick_gain(1500));
            end
            now_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                                 : $urandom;
            drift  = $urandom_range(0, 800) - 400;
            for (i = 0; i < 130; i++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_tick(16'($urandom), 1'($urandom), 1'($urandom), $urandom);
                end else begin
                    now_ms += ($urandom_range(0, 49) == 0) ? $urandom_range(2000, 3000)
                                                           : $urandom_range(50, 400);
                    drift += $urandom_range(0, 80) - 40;
                    if (drift > 600)  drift = 600;
                    if (drift < -600) drift = -600;
                    t_val = int'(sp_reg) + drift + $urandom_range(0, 20) - 10;
                    if (t_val > 32767)  t_val = 32767;
                    if (t_val < -32768) t_val = -32768;
                    send_tick(16'(t_val), ($urandom_range(0, 99) < 96),
                              ($urandom_range(0, 99) < 92), now_ms);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_after_reset();
        test_reset_gains();
        test_feedforward();
        test_windup_band();
        test_window_cycle();
        test_gain_extremes();

        test_random_traffic(650, 27, 80);
        test_random_traffic(650, 80, 27);
        test_random_traffic(650, 0, 0);

        wait_idle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
